FILE: rtl/sdh_pkg.sv
// Shared types and constants for the skeleton gap heal and de-stair block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
  localparam int MAX_GAP    = 60;
  localparam int COORD_BITS = 10;
  localparam int WID_BITS   = 12;
  localparam int NB = $clog2(MAX_GAP + 1);  // gap length bits
  localparam int RB = NB + 1;               // row/col remainder bits
  localparam int DW = NB + 5;               // width denominator bits (32*n)
  localparam int UW = WID_BITS + 1;         // divider dividend bits
  localparam int CB = $clog2(UW + 1);
  localparam int PW = WID_BITS - 3;         // rounded pixel width bits (0..256)

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t              row;
    coord_t              col;
    logic [WID_BITS-1:0] wid;
    logic                gap;
  } point_t;

  typedef struct packed {
    logic   flush;
    point_t pt;
  } cmd_t;

  typedef struct packed {
    point_t pt;
    logic   last;
  } res_t;

  function automatic logic near1(coord_t a, coord_t b);
    coord_t d;
    d = (a > b) ? a - b : b - a;
    return d <= coord_t'(1);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/sdh_front.sv
// Front part: accepts points, heals gaps by interpolation, issues push/flush commands.
// Depends on sdh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdh_front import sdh_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire coord_t              in_row,
  input  wire coord_t              in_col,
  input  wire logic [WID_BITS-1:0] in_width,
  input  wire logic                in_last,
  input  wire logic                push,
  output logic                     full,
  output logic                     q_push,
  output cmd_t                     q_cmd,
  input  wire logic                q_full
);
  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_EVAL  = 6'b000010,
    F_DIV   = 6'b000100,
    F_RUN   = 6'b001000,
    F_TAIL  = 6'b010000,
    F_FLUSH = 6'b100000
  } fstate_t;

  typedef struct packed {
    coord_t        q;
    logic [RB-1:0] r;
  } cstep_t;

  function automatic cstep_t cstep(coord_t q, logic [RB-1:0] r,
                                   logic [NB+1:0] d, logic [RB-1:0] d2);
    logic signed [NB+3:0] t;
    logic signed [NB+3:0] den;
    cstep_t o;
    den = $signed({3'b000, d2});
    t = $signed({3'b000, r}) + $signed({d[NB+1], d, 1'b0});
    if (t >= den) begin
      o.r = RB'(t - den);
      o.q = q + coord_t'(1);
    end else if (t < 0) begin
      o.r = RB'(t + den);
      o.q = q - coord_t'(1);
    end else begin
      o.r = t[RB-1:0];
      o.q = q;
    end
    return o;
  endfunction

  fstate_t st_r, st_nxt;
  point_t  cur_r, cur_nxt, prev_r, prev_nxt;
  logic    cur_last_r, cur_last_nxt;
  logic    have_r, have_nxt;
  coord_t  first_row_r, first_row_nxt, first_col_r, first_col_nxt;
  logic    tail_r, tail_nxt;
  logic    single_r, single_nxt, far_r, far_nxt;
  logic [NB-1:0] n_r, n_nxt, cnt_r, cnt_nxt;
  coord_t        qr_r, qr_nxt, qc_r, qc_nxt;
  logic [RB-1:0] rr_r, rr_nxt, rc_r, rc_nxt;
  logic [NB+1:0] dr_r, dr_nxt, dc_r, dc_nxt;
  logic [PW-1:0] qw_r, qw_nxt;
  logic [DW-1:0] rw_r, rw_nxt, rem_r, rem_nxt;
  logic [UW-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic          neg_r, neg_nxt;
  logic [CB-1:0] dcnt_r, dcnt_nxt;

  coord_t dy, dx, n;
  logic   near, far;
  logic [DW-1:0] den_w;
  logic [RB-1:0] den_c;
  logic [DW:0]   trial, tw;
  logic signed [PW+1:0] qs, qw_s;
  logic [DW-1:0] rs;
  logic signed [WID_BITS:0] dwid;
  logic [WID_BITS-1:0] mag;
  cstep_t sr, sc;

  assign dy    = (prev_r.row > cur_r.row) ? prev_r.row - cur_r.row : cur_r.row - prev_r.row;
  assign dx    = (prev_r.col > cur_r.col) ? prev_r.col - cur_r.col : cur_r.col - prev_r.col;
  assign n     = (dy > dx) ? dy : dx;
  assign near  = (dy <= coord_t'(1)) && (dx <= coord_t'(1));
  assign far   = n > coord_t'(MAX_GAP);
  assign den_w = {n_r, 5'b00000};
  assign den_c = {n_r, 1'b0};
  assign trial = {rem_r, dvd_r[UW-1]};
  assign dwid  = $signed({1'b0, cur_r.wid}) - $signed({1'b0, prev_r.wid});
  assign mag   = dwid[WID_BITS] ? WID_BITS'(-dwid) : dwid[WID_BITS-1:0];
  assign sr    = cstep(qr_r, rr_r, dr_r, den_c);
  assign sc    = cstep(qc_r, rc_r, dc_r, den_c);
  assign qw_s  = $signed({2'b00, qw_r});
  assign tw    = {1'b0, rw_r} + {1'b0, rs};
  assign full  = st_r != F_IDLE;

  always_comb begin
    if (!neg_r) begin
      qs = $signed({1'b0, quo_r[PW:0]});
      rs = rem_r;
    end else if (rem_r == '0) begin
      qs = -$signed({1'b0, quo_r[PW:0]});
      rs = '0;
    end else begin
      qs = -$signed({1'b0, quo_r[PW:0]}) - $signed((PW+2)'(1));
      rs = den_w - rem_r;
    end
  end

  always_comb begin
    st_nxt = st_r; cur_nxt = cur_r; prev_nxt = prev_r; cur_last_nxt = cur_last_r;
    have_nxt = have_r; first_row_nxt = first_row_r; first_col_nxt = first_col_r;
    tail_nxt = tail_r; single_nxt = single_r; far_nxt = far_r; n_nxt = n_r;
    cnt_nxt = cnt_r; qr_nxt = qr_r; qc_nxt = qc_r; rr_nxt = rr_r; rc_nxt = rc_r;
    dr_nxt = dr_r; dc_nxt = dc_r; qw_nxt = qw_r; rw_nxt = rw_r; rem_nxt = rem_r;
    dvd_nxt = dvd_r; quo_nxt = quo_r; neg_nxt = neg_r; dcnt_nxt = dcnt_r;
    q_push = 1'b0;
    q_cmd  = '0;
    unique case (st_r)
      F_IDLE: begin
        if (push) begin
          cur_nxt.row  = in_row;
          cur_nxt.col  = in_col;
          cur_nxt.wid  = (!have_r || in_last) ? '0 : in_width;
          cur_nxt.gap  = 1'b0;
          cur_last_nxt = in_last;
          st_nxt       = F_EVAL;
        end
      end
      F_EVAL: begin
        if (!have_r) begin
          first_row_nxt = cur_r.row;
          first_col_nxt = cur_r.col;
          if (!cur_last_r) begin
            prev_nxt = cur_r;
            have_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else begin
            tail_nxt = 1'b1;
            st_nxt   = F_TAIL;
          end
        end else begin
          n_nxt   = n[NB-1:0];
          cnt_nxt = '0;
          far_nxt = far;
          if (near || far) begin
            single_nxt = 1'b1;
            st_nxt     = F_RUN;
          end else begin
            single_nxt = 1'b0;
            qr_nxt   = prev_r.row;
            qc_nxt   = prev_r.col;
            rr_nxt   = {1'b0, n[NB-1:0]};
            rc_nxt   = {1'b0, n[NB-1:0]};
            dr_nxt   = (NB+2)'(cur_r.row - prev_r.row);
            dc_nxt   = (NB+2)'(cur_r.col - prev_r.col);
            qw_nxt   = PW'(({1'b0, prev_r.wid} + 13'd8) >> 4);
            rw_nxt   = DW'(n[NB-1:0]) * DW'({prev_r.wid[3:0] + 4'd8, 1'b0});
            rem_nxt  = '0;
            quo_nxt  = '0;
            dvd_nxt  = {mag, 1'b0};
            neg_nxt  = dwid[WID_BITS];
            dcnt_nxt = CB'(UW);
            st_nxt   = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, den_w}) begin
          rem_nxt = DW'(trial - {1'b0, den_w});
          quo_nxt = {quo_r[UW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_r[UW-2:0], 1'b0};
        end
        dvd_nxt  = {dvd_r[UW-2:0], 1'b0};
        dcnt_nxt = dcnt_r - CB'(1);
        if (dcnt_r == CB'(1)) st_nxt = F_RUN;
      end
      F_RUN: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (single_r) begin
            q_cmd.pt     = prev_r;
            q_cmd.pt.gap = far_r;
          end else begin
            q_cmd.pt.row = qr_r;
            q_cmd.pt.col = qc_r;
            q_cmd.pt.wid = qw_r[PW-1] ? '1 : {qw_r[PW-2:0], 4'b0000};
            q_cmd.pt.gap = 1'b0;
            qr_nxt = sr.q; rr_nxt = sr.r;
            qc_nxt = sc.q; rc_nxt = sc.r;
            if (tw >= {1'b0, den_w}) begin
              rw_nxt = DW'(tw - {1'b0, den_w});
              qw_nxt = PW'(qw_s + qs + 1);
            end else begin
              rw_nxt = tw[DW-1:0];
              qw_nxt = PW'(qw_s + qs);
            end
            cnt_nxt = cnt_r + NB'(1);
          end
          if (single_r || cnt_r == n_r - NB'(1)) begin
            prev_nxt = cur_r;
            tail_nxt = (cur_r.row != first_row_r) || (cur_r.col != first_col_r);
            st_nxt   = cur_last_r ? F_TAIL : F_IDLE;
          end
        end
      end
      F_TAIL: begin
        if (!tail_r) begin
          st_nxt = F_FLUSH;
        end else if (!q_full) begin
          q_push   = 1'b1;
          q_cmd.pt = cur_r;
          st_nxt   = F_FLUSH;
        end
      end
      F_FLUSH: begin
        if (!q_full) begin
          q_push      = 1'b1;
          q_cmd.flush = 1'b1;
          have_nxt    = 1'b0;
          st_nxt      = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      have_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      have_r <= have_nxt;
    end
    cur_r <= cur_nxt; prev_r <= prev_nxt; cur_last_r <= cur_last_nxt;
    first_row_r <= first_row_nxt; first_col_r <= first_col_nxt;
    tail_r <= tail_nxt; single_r <= single_nxt; far_r <= far_nxt; n_r <= n_nxt;
    cnt_r <= cnt_nxt; qr_r <= qr_nxt; qc_r <= qc_nxt; rr_r <= rr_nxt; rc_r <= rc_nxt;
    dr_r <= dr_nxt; dc_r <= dc_nxt; qw_r <= qw_nxt; rw_r <= rw_nxt; rem_r <= rem_nxt;
    dvd_r <= dvd_nxt; quo_r <= quo_nxt; neg_r <= neg_nxt; dcnt_r <= dcnt_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/sdh_cmdq.sv
// Four-entry command queue between the front and back parts.
// Depends on sdh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdh_cmdq import sdh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire cmd_t wdata,
  output logic      q_full,
  input  wire logic rd,
  output cmd_t      rdata,
  output logic      q_empty
);
  cmd_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_wr, do_rd;

  assign q_full  = cnt_r == 3'd4;
  assign q_empty = cnt_r == 3'd0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 2'd1;
      if (do_rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, do_wr} - {2'b00, do_rd};
    end
    if (do_wr) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

FILE: rtl/sdh_back.sv
// Back part: de-stair scan over healed points and a two-entry result queue.
// Depends on sdh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdh_back import sdh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output res_t      res,
  output logic      empty,
  input  wire logic pop
);
  point_t anc_r, anc_nxt, pend_r, pend_nxt;
  logic   anc_v_r, anc_v_nxt, pend_v_r, pend_v_nxt;
  res_t   oq_r [2];
  logic   wp_r, rp_r;
  logic [1:0] ocnt_r;
  logic   space, emit, do_pop;
  res_t   emit_d;

  assign space  = ocnt_r != 2'd2;
  assign empty  = ocnt_r == 2'd0;
  assign res    = oq_r[rp_r];
  assign do_pop = pop && !empty;

  always_comb begin
    anc_nxt = anc_r; pend_nxt = pend_r; anc_v_nxt = anc_v_r; pend_v_nxt = pend_v_r;
    emit = 1'b0; emit_d = '0; cmd_pop = 1'b0;
    if (!cmd_empty) begin
      if (cmd.flush) begin
        if (anc_v_r) begin
          if (space) begin
            emit        = 1'b1;
            emit_d.pt   = anc_r;
            emit_d.last = !pend_v_r;
            anc_v_nxt   = 1'b0;
            cmd_pop     = !pend_v_r;
          end
        end else if (pend_v_r) begin
          if (space) begin
            emit        = 1'b1;
            emit_d.pt   = pend_r;
            emit_d.last = 1'b1;
            pend_v_nxt  = 1'b0;
            cmd_pop     = 1'b1;
          end
        end else begin
          cmd_pop = 1'b1;
        end
      end else if (!anc_v_r) begin
        anc_nxt   = cmd.pt;
        anc_v_nxt = 1'b1;
        cmd_pop   = 1'b1;
      end else if (!pend_v_r) begin
        pend_nxt   = cmd.pt;
        pend_v_nxt = 1'b1;
        cmd_pop    = 1'b1;
      end else if (space) begin
        emit      = 1'b1;
        emit_d.pt = anc_r;
        cmd_pop   = 1'b1;
        if (near1(anc_r.row, cmd.pt.row) && near1(anc_r.col, cmd.pt.col)) begin
          anc_nxt     = cmd.pt;
          anc_nxt.gap = cmd.pt.gap | pend_r.gap;
          pend_v_nxt  = 1'b0;
        end else begin
          anc_nxt  = pend_r;
          pend_nxt = cmd.pt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      ocnt_r   <= '0;
    end else begin
      anc_v_r  <= anc_v_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      ocnt_r <= ocnt_r + {1'b0, emit} - {1'b0, do_pop};
    end
    anc_r  <= anc_nxt;
    pend_r <= pend_nxt;
    if (emit) oq_r[wp_r] <= emit_d;
  end
endmodule
`default_nettype wire

FILE: rtl/skeleton_gap_heal_and_destair_top.sv
// Skeleton gap heal and de-stair, top level. Uses sdh_pkg, sdh_front, sdh_cmdq, sdh_back.
// A point passes from the front through the command queue and the back part's result queue to the result ports.
// The front takes no new point while full is high. A gap of n runs a divider for the width step, then n
// interpolated points, one per cycle while q_full is low; the tail may add the last point, then a flush.
// Reset: synchronous active-low rst_n clears all control state and both queues.
`timescale 1ns / 1ps
`default_nettype none
module skeleton_gap_heal_and_destair_top import sdh_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire coord_t              in_row,
  input  wire coord_t              in_col,
  input  wire logic [WID_BITS-1:0] in_width,
  input  wire logic                in_last,
  input  wire logic                push,
  output logic                     full,
  output coord_t                   out_row,
  output coord_t                   out_col,
  output logic [WID_BITS-1:0]      out_width,
  output logic                     out_last,
  output logic                     out_gap_error,
  output logic                     empty,
  input  wire logic                pop
);
  logic q_push, q_full, q_empty, q_pop;
  cmd_t q_wdata, q_rdata;
  res_t res;

  sdh_front u_front (
    .clk, .rst_n, .in_row, .in_col, .in_width, .in_last, .push, .full,
    .q_push, .q_cmd(q_wdata), .q_full
  );

  sdh_cmdq u_cmdq (
    .clk, .rst_n, .wr(q_push), .wdata(q_wdata), .q_full,
    .rd(q_pop), .rdata(q_rdata), .q_empty
  );

  sdh_back u_back (
    .clk, .rst_n, .cmd(q_rdata), .cmd_empty(q_empty), .cmd_pop(q_pop),
    .res, .empty, .pop
  );

  assign out_row       = res.pt.row;
  assign out_col       = res.pt.col;
  assign out_width     = res.pt.wid;
  assign out_last      = res.last;
  assign out_gap_error = res.pt.gap;
endmodule
`default_nettype wire

FILE: verif/tb_skeleton_gap_heal_and_destair_top.sv
// Self-checking testbench for skeleton_gap_heal_and_destair_top: drives skeleton points, predicts
// healed and de-stepped points with a local model, and compares every popped point in order.
// Depends on sdh_pkg and the top-level RTL.
`timescale 1ns / 1ps

class skel_scoreboard;
  typedef struct {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [11:0] wid;
    logic        gap;
  } pt_s;
  typedef struct {
    pt_s  p;
    logic lst;
  } cleaned_s;

  pt_s prev_pt, first_pt, anchor_pt, pend_pt;
  bit have_prev, anchor_ok, pend_ok;
  cleaned_s cleaned_q[$];
  cleaned_s step_q[$];
  int mismatches;

  function void clear_state();
    prev_pt = '{0, 0, 0, 0};
    first_pt = prev_pt;
    anchor_pt = prev_pt;
    pend_pt = prev_pt;
    have_prev = 0;
    anchor_ok = 0;
    pend_ok = 0;
  endfunction

  function new();
    clear_state();
    mismatches = 0;
  endfunction

  function int unsigned adiff(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function void emit_pt(pt_s p);
    cleaned_s c;
    if (step_q.size() >= 64) return;
    c.p = p;
    c.lst = 0;
    step_q.push_back(c);
  endfunction

  function void destair(pt_s p);
    if (!anchor_ok) begin
      anchor_pt = p;
      anchor_ok = 1;
    end else if (!pend_ok) begin
      pend_pt = p;
      pend_ok = 1;
    end else if (adiff(anchor_pt.row, p.row) <= 1 && adiff(anchor_pt.col, p.col) <= 1) begin
      emit_pt(anchor_pt);
      p.gap = p.gap | pend_pt.gap;
      anchor_pt = p;
      pend_ok = 0;
    end else begin
      emit_pt(anchor_pt);
      anchor_pt = pend_pt;
      pend_pt = p;
    end
  endfunction

  function longint rdiv(longint num, longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  function void heal(pt_s a, pt_s b);
    int unsigned dy, dx, n;
    longint pix;
    pt_s q;
    dy = adiff(a.row, b.row);
    dx = adiff(a.col, b.col);
    n = dy > dx ? dy : dx;
    if (dy <= 1 && dx <= 1) begin
      destair(a);
      return;
    end
    if (n > 60) begin
      a.gap = 1;
      destair(a);
      return;
    end
    for (int m = 0; m < n; m++) begin
      q.row = 10'(rdiv(longint'(a.row) * n + m * (longint'(b.row) - longint'(a.row)), n));
      q.col = 10'(rdiv(longint'(a.col) * n + m * (longint'(b.col) - longint'(a.col)), n));
      pix = rdiv(longint'(a.wid) * n + m * (longint'(b.wid) - longint'(a.wid)), 16 * n);
      q.wid = pix * 16 > 4095 ? 12'hFFF : 12'(pix * 16);
      q.gap = 0;
      destair(q);
    end
  endfunction

  function void note_point(logic [9:0] row, logic [9:0] col, logic [11:0] wid, logic lst);
    pt_s cur;
    cur = '{row, col, wid, 1'b0};
    step_q.delete();
    if (!have_prev || lst) cur.wid = 0;
    if (!have_prev) begin
      first_pt = cur;
      if (!lst) begin
        prev_pt = cur;
        have_prev = 1;
        return;
      end
      destair(cur);
    end else begin
      heal(prev_pt, cur);
      prev_pt = cur;
      if (lst && (cur.row != first_pt.row || cur.col != first_pt.col)) destair(cur);
    end
    if (lst) begin
      if (anchor_ok) emit_pt(anchor_pt);
      if (pend_ok) emit_pt(pend_pt);
      if (step_q.size() > 0) step_q[step_q.size() - 1].lst = 1;
      clear_state();
    end
    foreach (step_q[i]) cleaned_q.push_back(step_q[i]);
  endfunction

  function void check_point(logic [9:0] row, logic [9:0] col, logic [11:0] wid, logic lst,
                            logic gap);
    cleaned_s e;
    if (cleaned_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected point: row=%0d col=%0d w=%0d last=%0d gap=%0d",
                 row, col, wid, lst, gap);
      return;
    end
    e = cleaned_q.pop_front();
    if (row !== e.p.row || col !== e.p.col || wid !== e.p.wid || lst !== e.lst ||
        gap !== e.p.gap) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp row=%0d col=%0d w=%0d last=%0d gap=%0d, got %0d %0d %0d %0d %0d",
                 e.p.row, e.p.col, e.p.wid, e.lst, e.p.gap, row, col, wid, lst, gap);
    end
  endfunction
endclass

module tb_skeleton_gap_heal_and_destair_top;
  import sdh_pkg::*;

  logic clk, rst_n;
  coord_t in_row, in_col;
  logic [WID_BITS-1:0] in_width;
  logic in_last, push, full;
  coord_t out_row, out_col;
  logic [WID_BITS-1:0] out_width;
  logic out_last, out_gap_error, empty, pop;

  skeleton_gap_heal_and_destair_top dut (
    .clk(clk), .rst_n(rst_n), .in_row(in_row), .in_col(in_col), .in_width(in_width),
    .in_last(in_last), .push(push), .full(full), .out_row(out_row), .out_col(out_col),
    .out_width(out_width), .out_last(out_last), .out_gap_error(out_gap_error),
    .empty(empty), .pop(pop)
  );

  skel_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0; push = 0; pop = 0;
    in_row = 0; in_col = 0; in_width = 0; in_last = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_point(out_row, out_col, out_width, out_last, out_gap_error);
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_point(coord_t r, coord_t c, logic [WID_BITS-1:0] w, logic l);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; in_row <= r; in_col <= c; in_width <= w; in_last <= l;
    do @(posedge clk); while (full);
    sb.note_point(r, c, w, l);
  endtask

  task automatic send_skeleton(int len);
    coord_t r, c, r0, c0;
    int dr, dc, mode;
    r = coord_t'($urandom); c = coord_t'($urandom);
    r0 = r; c0 = c;
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(99);
      if (i == len - 1 && $urandom_range(3) == 0) begin
        r = r0; c = c0;
      end else if (i > 0) begin
        if (mode < 60) begin
          dr = $urandom_range(2) - 1; dc = $urandom_range(2) - 1;
        end else if (mode < 92) begin
          dr = $urandom_range(20) - 10; dc = $urandom_range(20) - 10;
        end else begin
          dr = $urandom_range(200) - 100; dc = $urandom_range(200) - 100;
        end
        r = r + coord_t'(dr); c = c + coord_t'(dc);
      end
      send_point(r, c, WID_BITS'($urandom), i == len - 1);
    end
  endtask

  task automatic drain();
    push <= 0;
    while (sb.cleaned_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0; recv_stall_pct = 0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: single point, closed loop, long gap, width saturation, staircase
    send_point(10'd1023, 10'd1023, 12'hFFF, 1);
    send_point(0, 0, 12'hFFF, 0);
    send_point(0, 5, 12'hFFF, 0);
    send_point(5, 5, 12'hFFF, 0);
    send_point(0, 0, 12'h000, 1);
    send_point(100, 100, 12'h155, 0);
    send_point(100, 300, 12'hAAA, 0);
    send_point(101, 301, 12'hFFF, 0);
    send_point(102, 301, 12'h800, 0);
    send_point(1023, 0, 12'h7FF, 0);
    send_point(1000, 30, 12'h001, 1);
    send_point(5, 5, 0, 0);
    send_point(6, 5, 0, 0);
    send_point(6, 6, 0, 0);
    send_point(7, 6, 0, 0);
    send_point(7, 7, 0, 0);
    send_point(8, 9, 12'hFFF, 1);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 27) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 86 : 27) : 0;
      for (int k = 0; k < 5; k++) send_skeleton($urandom_range(12) + 1);
      drain();
    end
    if (sb.mismatches == 0 && sb.cleaned_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: sim.f
rtl/sdh_pkg.sv
rtl/sdh_front.sv
rtl/sdh_cmdq.sv
rtl/sdh_back.sv
rtl/skeleton_gap_heal_and_destair_top.sv
verif/tb_skeleton_gap_heal_and_destair_top.sv
